FILE: rtl/aip_pkg.sv
// Package for the ASCII integer parser: item structs, phase enum, status codes,
// register indexes and character constants. No dependencies.
package aip_pkg;

  // Input item: one byte of the string with end markers.
  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
    logic       empty_req;
  } in_item_t;

  // Result item: parsed bits and status.
  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } out_item_t;

  // Parse phase of the string in progress.
  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_STOP   = 2'd2
  } phase_t;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Number base codes.
  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_SELECT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_MODE = 1'b1;
  localparam int CFG_DATA_W = 2;

  // Register reset values.
  localparam logic [1:0] BASE_RESET   = BASE_DEC;
  localparam logic       SIGNED_RESET = 1'b1;

  // Character constants.
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Largest magnitudes in each mode.
  localparam logic [63:0] LIMIT_SIGNED   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIMIT_UNSIGNED = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

FILE: rtl/ascii_integer_parser.sv
// Top level of the ASCII integer parser: input register, per-character parse
// step and result register. Depends on aip_pkg.

// The block takes one string byte per item and returns one result per string,
// when the item marked last (or an empty_req item) has been taken. It accepts an
// item in every cycle while in_stall is low; each item is held in the input register,
// where a single shift-add and limit compare updates the accumulator, and the result
// of a closing item is written to the output register when that item advances.
// The only source of input stall is a full output register that is itself stalled
// while a closing item waits.
// Configuration registers are written through cfg_we, cfg_index and cfg_data.
module ascii_integer_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  aip_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output aip_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [aip_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [aip_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers.
  logic [1:0] base_select;
  logic       signed_mode;

  // Input register.
  logic              in_reg_valid;
  aip_pkg::in_item_t in_reg;

  // String state.
  aip_pkg::phase_t phase, phase_next;
  logic [63:0]     accumulator, accumulator_next;
  logic            negative, negative_next;
  logic            overflow, overflow_next;

  // Per-character datapath.
  logic        is_space, is_sign, is_digit, do_digit, ends_string, advance;
  logic [3:0]  digit;
  logic [67:0] product, sum;
  logic [63:0] limit, value_next;
  logic [1:0]  status_next;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_select <= aip_pkg::BASE_RESET;
      signed_mode <= aip_pkg::SIGNED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aip_pkg::REG_BASE_SELECT: base_select <= cfg_data[1:0];
        aip_pkg::REG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The held item moves on unless it closes a string and the result slot is stuck.
  assign ends_string = in_reg.last | in_reg.empty_req;
  assign advance     = in_reg_valid & (~ends_string | ~out_valid | ~out_stall);
  assign in_stall    = in_reg_valid & ~advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_item;
    end
  end

  // Character classes.
  assign is_space = (in_reg.char_in == aip_pkg::CH_SPACE) ||
                    ((in_reg.char_in >= aip_pkg::CH_TAB) && (in_reg.char_in <= aip_pkg::CH_CR));
  assign is_sign  = (in_reg.char_in == aip_pkg::CH_PLUS) ||
                    (in_reg.char_in == aip_pkg::CH_MINUS);

  // Digit value and whether it belongs to the configured base.
  always_comb begin
    logic       raw_ok;
    logic [7:0] raw;
    raw_ok = 1'b0;
    raw    = 8'd0;
    if ((in_reg.char_in >= aip_pkg::CH_0) && (in_reg.char_in <= aip_pkg::CH_9)) begin
      raw_ok = 1'b1;
      raw    = in_reg.char_in - aip_pkg::CH_0;
    end else if ((in_reg.char_in >= aip_pkg::CH_UA) && (in_reg.char_in <= aip_pkg::CH_UF)) begin
      raw_ok = 1'b1;
      raw    = in_reg.char_in - aip_pkg::CH_UA + 8'd10;
    end else if ((in_reg.char_in >= aip_pkg::CH_LA) && (in_reg.char_in <= aip_pkg::CH_LF)) begin
      raw_ok = 1'b1;
      raw    = in_reg.char_in - aip_pkg::CH_LA + 8'd10;
    end
    digit = raw[3:0];
    unique case (base_select)
      aip_pkg::BASE_BIN: is_digit = raw_ok && (raw < 8'd2);
      aip_pkg::BASE_OCT: is_digit = raw_ok && (in_reg.char_in <= aip_pkg::CH_7) &&
                                    (raw < 8'd8);
      aip_pkg::BASE_DEC: is_digit = raw_ok && (raw < 8'd10);
      aip_pkg::BASE_HEX: is_digit = raw_ok;
      default:           is_digit = 1'b0;
    endcase
  end

  // Shift-add of the next digit, kept four bits wider for the limit compare.
  always_comb begin
    unique case (base_select)
      aip_pkg::BASE_BIN: product = {3'd0, accumulator, 1'b0};
      aip_pkg::BASE_OCT: product = {1'b0, accumulator, 3'd0};
      aip_pkg::BASE_DEC: product = {1'b0, accumulator, 3'd0} + {3'd0, accumulator, 1'b0};
      aip_pkg::BASE_HEX: product = {accumulator, 4'd0};
      default:           product = '0;
    endcase
  end

  assign sum   = product + {64'd0, digit};
  assign limit = signed_mode ? aip_pkg::LIMIT_SIGNED : aip_pkg::LIMIT_UNSIGNED;

  // A byte is a digit candidate in the digit phase, or as the first non-blank non-sign.
  assign do_digit = ~in_reg.empty_req &&
                    ((phase == aip_pkg::PH_DIGITS) ||
                     ((phase == aip_pkg::PH_SKIP) && !is_space && !is_sign));

  // State update for one character.
  always_comb begin
    phase_next       = phase;
    accumulator_next = accumulator;
    negative_next    = negative;
    overflow_next    = overflow;
    if (!in_reg.empty_req && (phase == aip_pkg::PH_SKIP) && !is_space) begin
      phase_next = aip_pkg::PH_DIGITS;
      if (is_sign) begin
        negative_next = (in_reg.char_in == aip_pkg::CH_MINUS);
      end
    end
    if (do_digit) begin
      if (!is_digit) begin
        phase_next = aip_pkg::PH_STOP;
      end else if (sum > {4'd0, limit}) begin
        overflow_next = 1'b1;
        phase_next    = aip_pkg::PH_STOP;
      end else begin
        phase_next       = aip_pkg::PH_DIGITS;
        accumulator_next = sum[63:0];
      end
    end
  end

  // Result of a closing item, from the state after its character.
  always_comb begin
    if (phase_next == aip_pkg::PH_SKIP) begin
      status_next = aip_pkg::ST_INVALID;
      value_next  = '0;
    end else if (overflow_next) begin
      status_next = aip_pkg::ST_OVERFLOW;
      value_next  = '0;
    end else begin
      status_next = aip_pkg::ST_OK;
      value_next  = negative_next ? (64'd0 - accumulator_next) : accumulator_next;
    end
  end

  // String state registers; a closing item returns them to the start.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= aip_pkg::PH_SKIP;
      accumulator <= '0;
      negative    <= 1'b0;
      overflow    <= 1'b0;
    end else if (advance) begin
      if (ends_string) begin
        phase       <= aip_pkg::PH_SKIP;
        accumulator <= '0;
        negative    <= 1'b0;
        overflow    <= 1'b0;
      end else begin
        phase       <= phase_next;
        accumulator <= accumulator_next;
        negative    <= negative_next;
        overflow    <= overflow_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && ends_string) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ends_string) begin
      out_item.value  <= value_next;
      out_item.status <= status_next;
    end
  end

endmodule
